/* rtl/core/qll_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package qll_pkg;
    localparam int FEAT_N  = 16;
    localparam int FEAT_W  = 4;
    localparam int K_MAX   = 256;
    localparam int K_W     = 8;
    localparam int CNT_W   = 9;
    localparam int ACC_W   = 26;
    localparam int WADDR_W = FEAT_W + K_W;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_CHAN   = 2'd1;
    localparam logic [1:0] OP_ACT    = 2'd2;

    localparam logic [7:0] CFG_ISCALE = 8'd0;
    localparam logic [7:0] CFG_IZP    = 8'd1;
    localparam logic [7:0] CFG_LEN    = 8'd2;
    localparam logic [7:0] CFG_NF     = 8'd3;

    typedef struct packed {
        logic                     is_weight;
        logic                     is_chan;
        logic                     is_act;
        logic [FEAT_W-1:0]        row;
        logic [K_W-1:0]           column;
        logic signed [7:0]        value;
        logic [31:0]              scale;
        logic signed [7:0]        zp;
        logic signed [31:0]       bias;
    } item_t;

    typedef struct packed {
        logic [31:0]              iscale;
        logic signed [7:0]        izp;
        logic [CNT_W-1:0]         len;
        logic [FEAT_W-1:0]        last_f;
    } cfg_t;
endpackage
`default_nettype wire

/* rtl/core/qll_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module qll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/qll_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module qll_front
    import qll_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    output logic             q_valid,
    output item_t            q_item,
    input  wire logic        q_pop
);
    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      in_item;
    logic       push, pop;

    always_comb begin
        in_item.is_weight = (s_tuser == OP_WEIGHT);
        in_item.is_chan   = (s_tuser == OP_CHAN);
        in_item.is_act    = (s_tuser == OP_ACT);
        in_item.row       = s_tdata[3:0];
        in_item.column    = s_tdata[11:4];
        in_item.value     = s_tdata[19:12];
        in_item.scale     = s_tdata[51:20];
        in_item.zp        = s_tdata[59:52];
        in_item.bias      = s_tdata[91:60];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/qll_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module qll_back
    import qll_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  cfg_t             cfg,
    input  wire logic        q_valid,
    input  item_t            q_item,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,
    output logic             m_tlast
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MAC   = 4'd1;
    localparam logic [3:0] ST_DRAIN = 4'd2;
    localparam logic [3:0] ST_O0    = 4'd3;
    localparam logic [3:0] ST_O1    = 4'd4;
    localparam logic [3:0] ST_O2    = 4'd5;
    localparam logic [3:0] ST_O3    = 4'd6;
    localparam logic [3:0] ST_O4    = 4'd7;
    localparam logic [3:0] ST_O5    = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [FEAT_W-1:0]       f_reg, f_next;
    logic                    rd_v_reg;
    logic [FEAT_W-1:0]       rd_f_reg;
    logic signed [8:0]       xd_reg;

    logic [31:0]             scale_reg [FEAT_N];
    logic signed [7:0]       zp_reg    [FEAT_N];
    logic signed [31:0]      bias_reg  [FEAT_N];
    logic signed [ACC_W-1:0] acc_reg   [FEAT_N];

    logic [63:0]             sprod_reg;
    logic [ACC_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic signed [31:0]      bsel_reg;
    logic [57:0]             p0_reg, p1_reg;
    logic [89:0]             prod_reg;
    logic signed [58:0]      rq_reg;

    logic                    out_v_reg;
    logic [FEAT_W-1:0]       out_f_reg;
    logic [63:0]             out_res_reg;
    logic                    out_last_reg;

    logic                    ram_we;
    logic [WADDR_W-1:0]      ram_raddr;
    logic [7:0]              ram_rdata;
    logic signed [8:0]       wd;
    logic signed [17:0]      mac_prod;
    logic signed [ACC_W-1:0] acc_sel;
    logic [90:0]             sv, rnd;
    logic [63:0]             res;
    logic                    out_free, emit, row_done;

    qll_ram #(.WIDTH(8), .DEPTH(FEAT_N * K_MAX)) u_wram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr ({q_item.row, q_item.column}),
        .wdata (q_item.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q_pop     = (state_reg == ST_IDLE);
    assign ram_we    = q_pop && q_valid && q_item.is_weight;
    assign ram_raddr = {f_reg, count_reg[K_W-1:0]};

    assign wd       = $signed({ram_rdata[7], ram_rdata}) -
                      $signed({zp_reg[rd_f_reg][7], zp_reg[rd_f_reg]});
    assign mac_prod = xd_reg * wd;
    assign acc_sel  = acc_reg[f_reg];

    assign sv  = neg_reg ? (91'd0 - {1'b0, prod_reg}) : {1'b0, prod_reg};
    assign rnd = sv + (91'd1 << 31);
    assign res = {{5{rq_reg[58]}}, rq_reg} + {{32{bsel_reg[31]}}, bsel_reg};

    assign out_free = !out_v_reg || m_tready;
    assign emit     = (state_reg == ST_O5) && out_free;
    assign row_done = emit && (f_reg == cfg.last_f);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        f_next     = f_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_item.is_act) begin
                    f_next     = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                // issue one weight read per feature
                if (f_reg == cfg.last_f) begin
                    state_next = ST_DRAIN;
                end else begin
                    f_next = f_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                count_next = count_reg + 1'b1;
                f_next     = '0;
                state_next = (count_next >= cfg.len) ? ST_O0 : ST_IDLE;
            end
            ST_O0: state_next = ST_O1;
            ST_O1: state_next = ST_O2;
            ST_O2: state_next = ST_O3;
            ST_O3: state_next = ST_O4;
            ST_O4: state_next = ST_O5;
            ST_O5: begin
                if (emit) begin
                    if (row_done) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        f_next     = f_reg + 1'b1;
                        state_next = ST_O0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            f_reg     <= '0;
            rd_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            for (int i = 0; i < FEAT_N; i++) begin
                bias_reg[i] <= '0;
                acc_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            f_reg     <= f_next;
            rd_v_reg  <= (state_reg == ST_MAC);
            if (q_pop && q_valid && q_item.is_chan) begin
                bias_reg[q_item.row] <= q_item.bias;
            end
            if (row_done) begin
                for (int i = 0; i < FEAT_N; i++) begin
                    acc_reg[i] <= '0;
                end
            end else if (rd_v_reg) begin
                acc_reg[rd_f_reg] <= acc_reg[rd_f_reg] +
                                     {{(ACC_W-18){mac_prod[17]}}, mac_prod};
            end
            if (emit) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
        rd_f_reg <= f_reg;
        if (q_pop && q_valid && q_item.is_chan) begin
            scale_reg[q_item.row] <= q_item.scale;
            zp_reg[q_item.row]    <= q_item.zp;
        end
        if (q_pop && q_valid && q_item.is_act) begin
            xd_reg <= $signed({q_item.value[7], q_item.value}) -
                      $signed({cfg.izp[7], cfg.izp});
        end
        if (state_reg == ST_O0) begin
            sprod_reg <= {32'd0, cfg.iscale} * {32'd0, scale_reg[f_reg]};
            neg_reg   <= acc_sel[ACC_W-1];
            mag_reg   <= acc_sel[ACC_W-1] ? (ACC_W'(0) - acc_sel) : acc_sel;
            bsel_reg  <= bias_reg[f_reg];
        end
        if (state_reg == ST_O1) begin
            p0_reg <= {32'd0, mag_reg} * {26'd0, sprod_reg[31:0]};
        end
        if (state_reg == ST_O2) begin
            p1_reg <= {32'd0, mag_reg} * {26'd0, sprod_reg[63:32]};
        end
        if (state_reg == ST_O3) begin
            prod_reg <= {p1_reg, 32'd0} + {32'd0, p0_reg};
        end
        if (state_reg == ST_O4) begin
            rq_reg <= rnd[90:32];
        end
        if (emit) begin
            out_f_reg    <= f_reg;
            out_res_reg  <= res;
            out_last_reg <= (f_reg == cfg.last_f);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {4'd0, out_res_reg, out_f_reg};
    assign m_tlast  = out_last_reg;
endmodule
`default_nettype wire

/* rtl/core/int8_quantized_linear_layer_unit.sv */
//  channel   direction  content
//  s_*       in         tuser op; tdata row, column, value, channel_scale, zp, bias
//  m_*       out        tdata feature, result; tlast row_end
//  cfg_*     in         register index and write data
//  Loads are popped in the idle state. An activation holds the back end through
//  its pop, one weight read per feature, then drain. A row end runs each feature
//  through the output multiply chain, states O0 to O5; m_ back-pressure stalls it.
//  aresetn is synchronous; accumulators and biases clear at once, no sweep.
//  A two-entry request queue takes input, until full, while back end or m_ stalls.
`timescale 1ns / 1ps
`default_nettype none
module int8_quantized_linear_layer_unit
    import qll_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // row, column, value, channel_scale,
                                        // channel_zero_point, channel_bias, zeros
    input  wire logic [1:0]  s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // feature, result, zeros
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    logic [31:0]       iscale_reg;
    logic signed [7:0] izp_reg;
    logic [8:0]        len_reg;
    logic [4:0]        nf_reg;
    cfg_t              cfg;
    logic              q_valid, q_pop;
    item_t             q_item;
    logic [4:0]        nf_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iscale_reg <= 32'd16777216;
            izp_reg    <= '0;
            len_reg    <= 9'd256;
            nf_reg     <= 5'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ISCALE: iscale_reg <= cfg_data;
                CFG_IZP:    izp_reg    <= cfg_data[7:0];
                CFG_LEN:    len_reg    <= cfg_data[8:0];
                CFG_NF:     nf_reg     <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        nf_eff = (nf_reg == 5'd0) ? 5'd1 :
                 (nf_reg > 5'(FEAT_N)) ? 5'(FEAT_N) : nf_reg;
        cfg.iscale = iscale_reg;
        cfg.izp    = izp_reg;
        cfg.len    = (len_reg == '0) ? CNT_W'(1) :
                     (len_reg > CNT_W'(K_MAX)) ? CNT_W'(K_MAX) : len_reg;
        cfg.last_f = FEAT_W'(nf_eff - 5'd1);
    end

    qll_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    qll_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire
